// ===== sv/gcc_pkg.sv =====
// Package for the graph clustering counter: request, queue and response types,
// command and queue op codes, back-end state encoding, and a 64-bit popcount.
// No dependencies.
package gcc_pkg;

   localparam int MAX_NODES_DEFAULT   = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int NODE_W              = 6;
   localparam int NODE_COUNT_W        = 7;
   localparam int LINKED_W            = 13;
   localparam int DEGREE_W            = 7;
   localparam int POSSIBLE_W          = 12;
   localparam int TOTAL_W             = 19;

   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   localparam logic [1:0] CMD_ADD     = 2'd0;
   localparam logic [1:0] CMD_COMPUTE = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_COMPUTE,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_U,
      ST_ADD_V,
      ST_ROW,
      ST_ROW_CAP,
      ST_SCAN,
      ST_DRAIN
   } back_state_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [NODE_W-1:0] node_u;
      logic [NODE_W-1:0] node_v;
   } req_type;

   typedef struct packed {
      op_type            op;
      logic [NODE_W-1:0] node_u;
      logic [NODE_W-1:0] node_v;
   } queue_entry_type;

   typedef struct packed {
      logic [NODE_W-1:0]     node;
      logic [LINKED_W-1:0]   linked_pairs;
      logic [DEGREE_W-1:0]   degree;
      logic [POSSIBLE_W-1:0] possible_pairs;
      logic [TOTAL_W-1:0]    running_total;
      logic                  last;
   } rsp_type;

   function automatic logic [6:0] popcount64(input logic [63:0] x);
      logic [1:0] s1 [32];
      logic [2:0] s2 [16];
      logic [3:0] s3 [8];
      logic [4:0] s4 [4];
      logic [5:0] s5 [2];
      for (int i = 0; i < 32; i++) s1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
      for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
      for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
      for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
      for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
      return {1'b0, s5[0]} + {1'b0, s5[1]};
   endfunction

endpackage

// ===== sv/gcc_front.sv =====
// Front end: takes requests, drops invalid ones and turns the rest into queue ops.
// Depends on gcc_pkg.
module gcc_front
   import gcc_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   output logic            push_valid,
   input  logic            push_ready,
   output queue_entry_type push_entry
);

   logic in_range;

   assign in_range = (7'(req_data.node_u) < 7'(MAX_NODES)) &&
                     (7'(req_data.node_v) < 7'(MAX_NODES));
   assign req_stall = !push_ready;

   always_comb begin
      push_valid        = 1'b0;
      push_entry.op     = OP_ADD;
      push_entry.node_u = req_data.node_u;
      push_entry.node_v = req_data.node_v;
      unique case (req_data.command)
         CMD_ADD: begin
            push_valid = req_valid && in_range;
         end
         CMD_COMPUTE: begin
            push_valid    = req_valid;
            push_entry.op = OP_COMPUTE;
         end
         CMD_CLEAR: begin
            push_valid    = req_valid;
            push_entry.op = OP_CLEAR;
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/gcc_queue.sv =====
// Short op queue between front and back end, held in flip-flops.
// Depends on gcc_pkg.
module gcc_queue
   import gcc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  queue_entry_type push_entry,
   output logic            pop_valid,
   input  logic            pop_ready,
   output queue_entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/gcc_back.sv =====
// Back end: adjacency row memory with per-row valid bits, edge writes, the
// per-node scan pipeline and the response register. Depends on gcc_pkg.
module gcc_back
   import gcc_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [NODE_COUNT_W-1:0] node_count,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  queue_entry_type         pop_entry,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data
);

   localparam int NODE_AW = $clog2(MAX_NODES);

   logic [MAX_NODES-1:0] mem [MAX_NODES];
   logic [MAX_NODES-1:0] row_valid_ff, row_valid_in;

   back_state_type       state_ff, state_in;
   logic [NODE_AW-1:0]   u_ff, u_in, v_ff, v_in;
   logic [NODE_AW-1:0]   m_ff, m_in, k_ff, k_in;
   logic [NODE_COUNT_W-1:0] n_ff, n_in, n_sat;
   logic [MAX_NODES-1:0] mask_ff, mask_in, mask_new;
   logic [MAX_NODES-1:0] row_m_ff, row_m_in, row_k;
   logic [DEGREE_W-1:0]  deg_ff, deg_in;
   logic [LINKED_W-1:0]  linked_ff, linked_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;

   logic                 rd_en;
   logic [NODE_AW-1:0]   rd_addr;
   logic [MAX_NODES-1:0] rd_data_ff;
   logic                 rd_row_valid_ff;
   logic                 tag_v_ff, tag_v_in;
   logic [NODE_AW-1:0]   tag_ff, tag_in;
   logic                 pc_v_ff, pc_v_in;
   logic [6:0]           pc_ff, pc_in;

   logic                 wr_en;
   logic [NODE_AW-1:0]   wr_addr, wr_bit;

   logic                 out_free, emit, is_last;
   logic [13:0]          possible;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   assign pop_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign n_sat     = (node_count > NODE_COUNT_W'(MAX_NODES)) ?
                      NODE_COUNT_W'(MAX_NODES) : node_count;
   assign row_k     = rd_row_valid_ff ? rd_data_ff : '0;
   assign is_last   = (NODE_COUNT_W'(m_ff) + NODE_COUNT_W'(1)) == n_ff;
   assign possible  = 14'(deg_ff) * 14'(deg_ff - DEGREE_W'(1));

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         mask_new[i] = NODE_COUNT_W'(i) < n_sat;
      end
   end

   always_comb begin
      state_in     = state_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      mask_in      = mask_ff;
      row_m_in     = row_m_ff;
      deg_in       = deg_ff;
      total_in     = total_ff;
      row_valid_in = row_valid_ff;
      rd_en        = 1'b0;
      rd_addr      = m_ff;
      wr_en        = 1'b0;
      wr_addr      = u_ff;
      wr_bit       = v_ff;
      tag_v_in     = 1'b0;
      tag_in       = k_ff;
      emit         = 1'b0;

      pc_v_in   = tag_v_ff;
      pc_in     = row_m_ff[tag_ff] ? popcount64(64'(row_m_ff & row_k)) : 7'd0;
      linked_in = pc_v_ff ? linked_ff + LINKED_W'(pc_ff) : linked_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               unique case (pop_entry.op)
                  OP_ADD: begin
                     u_in     = pop_entry.node_u[NODE_AW-1:0];
                     v_in     = pop_entry.node_v[NODE_AW-1:0];
                     state_in = ST_ADD_U;
                  end
                  OP_COMPUTE: begin
                     n_in     = n_sat;
                     mask_in  = mask_new;
                     m_in     = '0;
                     total_in = '0;
                     if (n_sat != '0) begin
                        state_in = ST_ROW;
                     end
                  end
                  OP_CLEAR: begin
                     row_valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_U: begin
            wr_en    = 1'b1;
            state_in = ST_ADD_V;
         end
         ST_ADD_V: begin
            wr_en    = 1'b1;
            wr_addr  = v_ff;
            wr_bit   = u_ff;
            state_in = ST_IDLE;
         end
         ST_ROW: begin
            rd_en    = 1'b1;
            state_in = ST_ROW_CAP;
         end
         ST_ROW_CAP: begin
            row_m_in  = row_k & mask_ff;
            deg_in    = popcount64(64'(row_k & mask_ff));
            linked_in = '0;
            k_in      = '0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            tag_v_in = 1'b1;
            if ((NODE_COUNT_W'(k_ff) + NODE_COUNT_W'(1)) == n_ff) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + NODE_AW'(1);
            end
         end
         ST_DRAIN: begin
            if (!tag_v_ff && !pc_v_ff && out_free) begin
               emit     = 1'b1;
               total_in = total_ff + TOTAL_W'(linked_ff);
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  m_in     = m_ff + NODE_AW'(1);
                  state_in = ST_ROW;
               end
            end
         end
      endcase

      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         tag_v_ff     <= 1'b0;
         pc_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         tag_v_ff     <= tag_v_in;
         pc_v_ff      <= pc_v_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      u_ff      <= u_in;
      v_ff      <= v_in;
      m_ff      <= m_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
      mask_ff   <= mask_in;
      row_m_ff  <= row_m_in;
      deg_ff    <= deg_in;
      linked_ff <= linked_in;
      total_ff  <= total_in;
      tag_ff    <= tag_in;
      pc_ff     <= pc_in;
      if (emit) begin
         rsp_ff.node           <= NODE_W'(m_ff);
         rsp_ff.linked_pairs   <= linked_ff;
         rsp_ff.degree         <= deg_ff;
         rsp_ff.possible_pairs <= possible[POSSIBLE_W-1:0];
         rsp_ff.running_total  <= total_in;
         rsp_ff.last           <= is_last;
      end
   end

   // row memory: one write port with a single-bit write into valid rows,
   // one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (row_valid_ff[wr_addr]) begin
            mem[wr_addr][wr_bit] <= 1'b1;
         end else begin
            mem[wr_addr] <= MAX_NODES'(1) << wr_bit;
         end
      end
      if (rd_en) begin
         rd_data_ff      <= mem[rd_addr];
         rd_row_valid_ff <= row_valid_ff[rd_addr];
      end
   end

endmodule

// ===== sv/graph_clustering_counter_core.sv =====
// Top level of the graph clustering counter: node count register, front end,
// op queue and back end. Depends on gcc_pkg, gcc_front, gcc_queue, gcc_back.
//
// Usage:
//   req_*  : request channel (valid/stall). command 0 adds edge node_u-node_v,
//            1 scans all nodes below node_count, 2 clears the matrix.
//   rsp_*  : one response per scanned node, last set on the final node.
//   csr_*  : writes node_count (reset 64); write only while the block is idle.
// Operation:
//   The front end takes one request per cycle into a QUEUE_DEPTH-entry queue
//   while the queue has room. An add edge does its two row writes in ST_ADD_U
//   and ST_ADD_V; a clear resets all row valid bits in ST_IDLE. A compute with
//   n nodes pops, then per node reads and captures its row, reads n neighbor rows
//   through the single memory read port and drains the popcount pipeline.
// Reset clears all row valid bits at once, so the matrix reads as empty
// immediately; no clearing pass is needed. When rsp_stall is high the response
// register holds and the scan waits; requests keep queueing until the queue fills.
module graph_clustering_counter_core
   import gcc_pkg::*;
#(
   parameter int MAX_NODES   = MAX_NODES_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [NODE_COUNT_W-1:0] csr_data
);

   logic [NODE_COUNT_W-1:0] node_count_ff;
   logic                    push_valid, push_ready;
   queue_entry_type         push_entry;
   logic                    pop_valid, pop_ready;
   queue_entry_type         pop_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         node_count_ff <= csr_data;
      end
   end

   gcc_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   gcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   gcc_back #(
      .MAX_NODES (MAX_NODES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .node_count (node_count_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
